// ----- src/obr_pkg.sv -----
`default_nettype none
package obr_pkg;

  localparam int PRICE_W = 24;
  localparam int TIME_W  = 48;
  localparam int VOL_W   = 32;
  localparam int VSUM_W  = 40;
  localparam int WSUM_W  = 64;
  localparam int CNT_W   = 32;
  localparam int BW_W    = 32;

  localparam int CFG_W     = (TIME_W > BW_W) ? TIME_W : BW_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd2;

  localparam logic [TIME_W-1:0]  START_RESET = '0;
  localparam logic [TIME_W-1:0]  END_RESET   = '1;
  localparam logic [BW_W-1:0]    WIDTH_RESET = BW_W'(60000);
  localparam logic [PRICE_W-1:0] PRICE_MAX   = '1;

  // (high + low) * volume before it joins the running sum.
  localparam int PROD_W = PRICE_W + 1 + VOL_W;
  localparam int WADD_W = ((PROD_W > WSUM_W) ? PROD_W : WSUM_W) + 1;

  // One shared divider serves both the bucket offset and the VWAP.
  localparam int DIV_NUM_W = (WSUM_W > TIME_W) ? WSUM_W : TIME_W;
  localparam int DIV_DEN_W = ((VSUM_W + 1) > BW_W) ? (VSUM_W + 1) : BW_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [VOL_W-1:0]   traded_volume;
    logic               end_of_stream;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  bucket_begin;
    logic [PRICE_W-1:0] bar_open;
    logic [PRICE_W-1:0] bar_high;
    logic [PRICE_W-1:0] bar_low;
    logic [PRICE_W-1:0] bar_close;
    logic [VSUM_W-1:0]  bar_volume;
    logic [PRICE_W-1:0] bar_vwap;
    logic [CNT_W-1:0]   bar_count;
    logic               saturated;
    logic               final_bar;
    logic               last_of_run;
  } bar_t;

  typedef struct packed {
    logic take;
    logic div_ts;
    logic div_vw;
    logic ld_begin;
    logic grid_set;
    logic emit;
    logic emit_final;
    logic emit_last;
    logic clear_new;
    logic clear_start;
    logic accum;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic fast_hit;
    logic eos;
    logic has_data;
    logic div_busy;
    logic later;
    logic not_behind;
    logic vol_zero;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/obr_div.sv -----
`default_nettype none
module obr_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [obr_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [obr_pkg::DIV_DEN_W-1:0] den,
  output logic                               busy,
  output logic      [obr_pkg::DIV_NUM_W-1:0] quo,
  output logic      [obr_pkg::DIV_DEN_W-1:0] rem
);
  import obr_pkg::*;

  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- src/obr_dp.sv -----
`default_nettype none
module obr_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire obr_pkg::item_t                rec,
  input  wire logic                          cfg_valid,
  input  wire logic [obr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [obr_pkg::CFG_W-1:0]     cfg_data,
  input  wire obr_pkg::cmd_t                 cmd,
  output obr_pkg::stat_t                     stat,
  output logic                               bar_valid,
  input  wire logic                          bar_ready,
  output obr_pkg::bar_t                      bar
);
  import obr_pkg::*;

  item_t              cur;
  logic [TIME_W-1:0]  start_time;
  logic [TIME_W-1:0]  end_time;
  logic [BW_W-1:0]    bucket_width;
  logic [BW_W-1:0]    width_eff;

  logic [TIME_W-1:0]  current_begin;
  logic [TIME_W-1:0]  begin_new;
  logic [TIME_W:0]    bound;
  logic               grid_ok;

  logic               has_data;
  logic [PRICE_W-1:0] cur_open;
  logic [PRICE_W-1:0] cur_high;
  logic [PRICE_W-1:0] cur_low;
  logic [PRICE_W-1:0] cur_close;
  logic [VSUM_W-1:0]  volume_sum;
  logic [WSUM_W-1:0]  weighted_sum;
  logic [CNT_W-1:0]   record_count;
  logic               sat_flag;

  logic [PRICE_W:0]   mid;
  logic [PROD_W-1:0]  prod;
  logic [VSUM_W:0]    vsum_add;
  logic               vsum_ovf;
  logic               count_max;
  logic [WADD_W-1:0]  wsum_add;
  logic               wsum_ovf;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_busy;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  logic [DIV_NUM_W-1:0] vwap_round;
  logic [PRICE_W-1:0]   vwap;

  assign width_eff = (bucket_width == '0) ? BW_W'(1) : bucket_width;

  assign mid       = {1'b0, cur.high_price} + {1'b0, cur.low_price};
  assign vsum_add  = {1'b0, volume_sum} + (VSUM_W+1)'(cur.traded_volume);
  assign vsum_ovf  = vsum_add[VSUM_W];
  assign count_max = &record_count;
  assign wsum_add  = WADD_W'(weighted_sum) + WADD_W'(prod);
  assign wsum_ovf  = |wsum_add[WADD_W-1:WSUM_W];

  // The product is registered every cycle; it is ready by the time a record reaches the accumulate step.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mid) * PROD_W'(cur.traded_volume);
  end

  assign div_start = cmd.div_ts | cmd.div_vw;
  assign div_num   = cmd.div_vw ? DIV_NUM_W'(weighted_sum)
                                : DIV_NUM_W'(cur.stamp - start_time);
  assign div_den   = cmd.div_vw ? DIV_DEN_W'({volume_sum, 1'b0})
                                : DIV_DEN_W'(width_eff);

  obr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Round half up: a remainder of at least half of 2*volume is at least volume.
  assign vwap_round = div_quo + DIV_NUM_W'(div_rem >= DIV_DEN_W'(volume_sum));
  always_comb begin
    if (volume_sum == '0) begin
      vwap = '0;
    end else if (vwap_round > DIV_NUM_W'(PRICE_MAX)) begin
      vwap = PRICE_MAX;
    end else begin
      vwap = vwap_round[PRICE_W-1:0];
    end
  end

  always_comb begin
    stat.in_range   = (cur.stamp >= start_time) && (cur.stamp <= end_time);
    stat.fast_hit   = grid_ok && ({1'b0, cur.stamp} < bound);
    stat.eos        = cur.end_of_stream;
    stat.has_data   = has_data;
    stat.div_busy   = div_busy;
    stat.later      = (begin_new > current_begin);
    stat.not_behind = (begin_new >= current_begin);
    stat.vol_zero   = (volume_sum == '0);
    stat.out_free   = !bar_valid || bar_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur <= rec;
    end
    if (cmd.ld_begin) begin
      begin_new <= cur.stamp - TIME_W'(div_rem);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time    <= START_RESET;
      end_time      <= END_RESET;
      bucket_width  <= WIDTH_RESET;
      current_begin <= START_RESET;
      grid_ok       <= 1'b0;
      bound         <= '0;
      has_data      <= 1'b0;
      cur_open      <= '0;
      cur_high      <= '0;
      cur_low       <= '0;
      cur_close     <= '0;
      volume_sum    <= '0;
      weighted_sum  <= '0;
      record_count  <= '0;
      sat_flag      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_START: begin
            start_time <= TIME_W'(cfg_data);
            grid_ok    <= 1'b0;
            if (!has_data) begin
              current_begin <= TIME_W'(cfg_data);
            end
          end
          CFG_END: begin
            end_time <= TIME_W'(cfg_data);
          end
          CFG_WIDTH: begin
            bucket_width <= BW_W'(cfg_data);
            grid_ok      <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      // A grid-aligned current bucket lets later records skip the divider.
      if (cmd.grid_set) begin
        grid_ok <= 1'b1;
        bound   <= (TIME_W+1)'(begin_new) + (TIME_W+1)'(width_eff);
      end

      if (cmd.clear_new || cmd.clear_start) begin
        has_data      <= 1'b0;
        cur_open      <= '0;
        cur_high      <= '0;
        cur_low       <= '0;
        cur_close     <= '0;
        volume_sum    <= '0;
        weighted_sum  <= '0;
        record_count  <= '0;
        sat_flag      <= 1'b0;
        current_begin <= cmd.clear_new ? begin_new : start_time;
        if (cmd.clear_start) begin
          grid_ok <= 1'b0;
        end
      end

      if (cmd.accum) begin
        if (!has_data) begin
          cur_open <= cur.open_price;
          cur_high <= cur.high_price;
          cur_low  <= cur.low_price;
          has_data <= 1'b1;
        end else begin
          if (cur.high_price > cur_high) begin
            cur_high <= cur.high_price;
          end
          if (cur.low_price < cur_low) begin
            cur_low <= cur.low_price;
          end
        end
        cur_close    <= cur.close_price;
        volume_sum   <= vsum_ovf ? '1 : vsum_add[VSUM_W-1:0];
        record_count <= count_max ? record_count : record_count + 1'b1;
        weighted_sum <= wsum_ovf ? '1 : wsum_add[WSUM_W-1:0];
        sat_flag     <= sat_flag | vsum_ovf | count_max | wsum_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_valid <= 1'b0;
    end else if (cmd.emit) begin
      bar_valid <= 1'b1;
    end else if (bar_ready) begin
      bar_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bar.bucket_begin <= current_begin;
      bar.bar_open     <= cur_open;
      bar.bar_high     <= cur_high;
      bar.bar_low      <= cur_low;
      bar.bar_close    <= cur_close;
      bar.bar_volume   <= volume_sum;
      bar.bar_vwap     <= vwap;
      bar.bar_count    <= record_count;
      bar.saturated    <= sat_flag;
      bar.final_bar    <= cmd.emit_final;
      bar.last_of_run  <= cmd.emit_last;
    end
  end

endmodule
`default_nettype wire

// ----- src/obr_ctrl.sv -----
`default_nettype none
module obr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           rec_valid,
  output logic                rec_ready,
  input  wire obr_pkg::stat_t stat,
  output obr_pkg::cmd_t       cmd
);
  import obr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_TSDIV = 4'd2;
  localparam logic [3:0] S_MOVE  = 4'd3;
  localparam logic [3:0] S_VWM   = 4'd4;
  localparam logic [3:0] S_EMITM = 4'd5;
  localparam logic [3:0] S_ACCUM = 4'd6;
  localparam logic [3:0] S_EOS   = 4'd7;
  localparam logic [3:0] S_VWE   = 4'd8;
  localparam logic [3:0] S_EMITE = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    rec_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        rec_ready = 1'b1;
        if (rec_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.in_range) begin
          state_next = stat.eos ? S_EOS : S_IDLE;
        end else if (stat.fast_hit) begin
          state_next = S_ACCUM;
        end else begin
          cmd.div_ts = 1'b1;
          state_next = S_TSDIV;
        end
      end
      S_TSDIV: begin
        if (!stat.div_busy) begin
          cmd.ld_begin = 1'b1;
          state_next   = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.grid_set = stat.not_behind;
        if (!stat.later) begin
          state_next = S_ACCUM;
        end else if (!stat.has_data) begin
          cmd.clear_new = 1'b1;
          state_next    = S_ACCUM;
        end else if (stat.vol_zero) begin
          state_next = S_EMITM;
        end else begin
          cmd.div_vw = 1'b1;
          state_next = S_VWM;
        end
      end
      S_VWM: begin
        if (!stat.div_busy) begin
          state_next = S_EMITM;
        end
      end
      S_EMITM: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = !stat.eos;
          cmd.clear_new = 1'b1;
          state_next    = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        if (stat.eos) begin
          state_next = S_EOS;
        end else begin
          // The next word can be taken while this one is folded in.
          rec_ready = 1'b1;
          if (rec_valid) begin
            cmd.take   = 1'b1;
            state_next = S_CHECK;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EOS: begin
        if (!stat.has_data) begin
          cmd.clear_start = 1'b1;
          state_next      = S_IDLE;
        end else if (stat.vol_zero) begin
          state_next = S_EMITE;
        end else begin
          cmd.div_vw = 1'b1;
          state_next = S_VWE;
        end
      end
      S_VWE: begin
        if (!stat.div_busy) begin
          state_next = S_EMITE;
        end
      end
      S_EMITE: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_final  = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.clear_start = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/ohlcv_bucket_resampler.sv -----
`default_nettype none
// OHLCV bar builder for one symbol's time-ordered records. A record whose bucket matches
// the open bucket passes a check step, then an accumulate step in which the next word
// can be accepted. The first record of a stream, the first after a start or width
// write, and every record that crosses into a later bucket run the bit-serial divider
// for the bucket offset. Emitting a bar with nonzero volume runs the same divider again
// for the VWAP before the bar is loaded into the output register. Results sit in a
// one-word output register; a new record is accepted while a bar waits there, and
// output back-pressure only stalls the block when it must emit another bar into the
// occupied register.
module ohlcv_bucket_resampler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rec_valid,
  output logic                               rec_ready,
  input  wire obr_pkg::item_t                rec,
  output logic                               bar_valid,
  input  wire logic                          bar_ready,
  output obr_pkg::bar_t                      bar,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [obr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [obr_pkg::CFG_W-1:0]     cfg_data
);
  import obr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  obr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  obr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .bar_valid (bar_valid),
    .bar_ready (bar_ready),
    .bar       (bar)
  );

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!bar_valid || bar_ready))
    else $error("bar loaded while the output register was still full");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_ts || cmd.div_vw) |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    bar_valid |-> (!bar.final_bar || bar.last_of_run))
    else $error("end-of-stream bar not marked as last of its run");

  a_accum_sets_data: assert property (@(posedge clk) disable iff (rst)
    cmd.accum |=> stat.has_data)
    else $error("bucket empty after a record was accumulated");

endmodule
`default_nettype wire

// ----- tb/tb_ohlcv_bucket_resampler.sv -----
`default_nettype none
module tb_ohlcv_bucket_resampler;
  import obr_pkg::*;

  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 rec_valid;
  logic                 rec_ready;
  item_t                rec;
  logic                 bar_valid;
  logic                 bar_ready;
  bar_t                 bar;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bit failed        = 1'b0;
  bit idle_on       = 1'b1;
  int sink_hold_req = 0;

  // Register mirror and the open bucket, as the block should hold them.
  logic [TIME_W-1:0]  win_start;
  logic [TIME_W-1:0]  win_end;
  logic [BW_W-1:0]    win_width;
  logic [TIME_W-1:0]  acc_begin;
  logic               acc_live;
  logic [PRICE_W-1:0] acc_open;
  logic [PRICE_W-1:0] acc_high;
  logic [PRICE_W-1:0] acc_low;
  logic [PRICE_W-1:0] acc_close;
  logic [VSUM_W-1:0]  acc_vol;
  logic [WSUM_W-1:0]  acc_wsum;
  logic [CNT_W-1:0]   acc_cnt;
  logic               acc_sat;

  bar_t bars_due[$];

  ohlcv_bucket_resampler dut (
    .clk(clk),
    .rst(rst),
    .rec_valid(rec_valid),
    .rec_ready(rec_ready),
    .rec(rec),
    .bar_valid(bar_valid),
    .bar_ready(bar_ready),
    .bar(bar),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_acc();
    acc_live  = 1'b0;
    acc_open  = '0;
    acc_high  = '0;
    acc_low   = '0;
    acc_close = '0;
    acc_vol   = '0;
    acc_wsum  = '0;
    acc_cnt   = '0;
    acc_sat   = 1'b0;
  endfunction

  function automatic void reset_predictor();
    win_start = START_RESET;
    win_end   = END_RESET;
    win_width = WIDTH_RESET;
    clear_acc();
    acc_begin = win_start;
  endfunction

  function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
    case (idx)
      CFG_START: begin
        win_start = val[TIME_W-1:0];
        if (!acc_live) acc_begin = win_start;
      end
      CFG_END:   win_end = val[TIME_W-1:0];
      CFG_WIDTH: win_width = val[BW_W-1:0];
      default: ;
    endcase
  endfunction

  // Weighted sum over twice the volume, rounded half up, clamped to a price.
  function automatic logic [PRICE_W-1:0] mid_vwap();
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    if (acc_vol == '0) return '0;
    d = {23'd0, acc_vol, 1'b0};
    q = acc_wsum / d;
    r = acc_wsum % d;
    if ({r[62:0], 1'b0} >= d && q != '1) q++;
    return (q > 64'(PRICE_MAX)) ? PRICE_MAX : q[PRICE_W-1:0];
  endfunction

  function automatic void close_bar(input bit flushed);
    bar_t b;
    b.bucket_begin = acc_begin;
    b.bar_open     = acc_open;
    b.bar_high     = acc_high;
    b.bar_low      = acc_low;
    b.bar_close    = acc_close;
    b.bar_volume   = acc_vol;
    b.bar_vwap     = mid_vwap();
    b.bar_count    = acc_cnt;
    b.saturated    = acc_sat;
    b.final_bar    = flushed;
    b.last_of_run  = 1'b0;
    bars_due.insert(bars_due.size(), b);
  endfunction

  function automatic void fold_record(input item_t it);
    logic [PRICE_W:0]        mid;
    logic [PROD_W-1:0]       prod;
    logic [VSUM_W:0]         vsum;
    logic [WSUM_W:0]         wsum;
    mid  = {1'b0, it.high_price} + {1'b0, it.low_price};
    prod = PROD_W'(mid) * PROD_W'(it.traded_volume);
    if (!acc_live) begin
      acc_open = it.open_price;
      acc_high = it.high_price;
      acc_low  = it.low_price;
      acc_live = 1'b1;
    end else begin
      if (it.high_price > acc_high) acc_high = it.high_price;
      if (it.low_price < acc_low) acc_low = it.low_price;
    end
    acc_close = it.close_price;
    vsum = {1'b0, acc_vol} + (VSUM_W+1)'(it.traded_volume);
    if (vsum[VSUM_W]) begin
      acc_vol = '1;
      acc_sat = 1'b1;
    end else begin
      acc_vol = vsum[VSUM_W-1:0];
    end
    if (acc_cnt == '1) acc_sat = 1'b1;
    else acc_cnt++;
    wsum = {1'b0, acc_wsum} + (WSUM_W+1)'(prod);
    if (wsum[WSUM_W]) begin
      acc_wsum = '1;
      acc_sat  = 1'b1;
    end else begin
      acc_wsum = wsum[WSUM_W-1:0];
    end
  endfunction

  function automatic void predict_record(input item_t it);
    logic [TIME_W-1:0] weff;
    logic [TIME_W-1:0] slot;
    bar_t              tail;
    int                n;
    n = 0;
    if (it.stamp >= win_start && it.stamp <= win_end) begin
      weff = (win_width == '0) ? TIME_W'(1) : TIME_W'(win_width);
      slot = win_start + ((it.stamp - win_start) / weff) * weff;
      if (slot > acc_begin) begin
        if (acc_live) begin
          close_bar(1'b0);
          n++;
        end
        clear_acc();
        acc_begin = slot;
      end
      fold_record(it);
    end
    if (it.end_of_stream) begin
      if (acc_live) begin
        close_bar(1'b1);
        n++;
      end
      clear_acc();
      acc_begin = win_start;
    end
    if (n > 0) begin
      tail = bars_due.pop_back();
      tail.last_of_run = 1'b1;
      bars_due.insert(bars_due.size(), tail);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : bar_check
    bar_t want;
    if (!rst && bar_valid && bar_ready) begin
      if (bars_due.size() == 0) begin
        $error("bar at %0h arrived with no bar pending", bar.bucket_begin);
        failed = 1'b1;
      end else begin
        want = bars_due.pop_front();
        check_field("bucket_begin", 64'(want.bucket_begin), 64'(bar.bucket_begin));
        check_field("bar_open", 64'(want.bar_open), 64'(bar.bar_open));
        check_field("bar_high", 64'(want.bar_high), 64'(bar.bar_high));
        check_field("bar_low", 64'(want.bar_low), 64'(bar.bar_low));
        check_field("bar_close", 64'(want.bar_close), 64'(bar.bar_close));
        check_field("bar_volume", 64'(want.bar_volume), 64'(bar.bar_volume));
        check_field("bar_vwap", 64'(want.bar_vwap), 64'(bar.bar_vwap));
        check_field("bar_count", 64'(want.bar_count), 64'(bar.bar_count));
        check_field("saturated", 64'(want.saturated), 64'(bar.saturated));
        check_field("final_bar", 64'(want.final_bar), 64'(bar.final_bar));
        check_field("last_of_run", 64'(want.last_of_run), 64'(bar.last_of_run));
      end
    end
  end

  // Output sink: short random stalls, plus one long hold when a test asks for it.
  initial begin : bar_sink
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    bar_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        hold_left     = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        bar_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        bar_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 4);
        bar_ready <= 1'b0;
      end else begin
        bar_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((rec_valid && rec_ready) || (bar_valid && bar_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_rec(input item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      rec_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    rec       <= it;
    rec_valid <= 1'b1;
    @(posedge clk);
    while (!rec_ready) @(posedge clk);
    predict_record(it);
  endtask

  // Registers change only once the block is idle: every bar is back and any
  // record that makes no bar has had time to finish its division.
  task automatic settle();
    rec_valid <= 1'b0;
    while (bars_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror_reg(idx, val);
  endtask

  task automatic set_window(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                            input logic [BW_W-1:0] w);
    write_reg(CFG_START, s);
    write_reg(CFG_END, e);
    // The width word carries junk above bit 31, which the block must ignore.
    write_reg(CFG_WIDTH, CFG_W'({16'($urandom), w}));
    cfg_valid <= 1'b0;
  endtask

  task automatic set_start(input logic [TIME_W-1:0] s);
    write_reg(CFG_START, s);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] rand48();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [PRICE_W-1:0] rand_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PRICE_MAX;
      default: return PRICE_W'($urandom);
    endcase
  endfunction

  function automatic item_t rec_of(input logic [TIME_W-1:0] stamp,
                                   input logic [PRICE_W-1:0] o, input logic [PRICE_W-1:0] h,
                                   input logic [PRICE_W-1:0] l, input logic [PRICE_W-1:0] c,
                                   input logic [VOL_W-1:0] v, input bit eos);
    item_t it;
    it.stamp         = stamp;
    it.open_price    = o;
    it.high_price    = h;
    it.low_price     = l;
    it.close_price   = c;
    it.traded_volume = v;
    it.end_of_stream = eos;
    return it;
  endfunction

  function automatic item_t rand_rec(input logic [TIME_W-1:0] stamp, input bit eos);
    logic [VOL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = $urandom_range(1, 1000);
      default: v = $urandom;
    endcase
    return rec_of(stamp, rand_price(), rand_price(), rand_price(), rand_price(), v, eos);
  endfunction

  function automatic logic [63:0] stream_start(input logic [63:0] weff);
    logic [63:0] t;
    if (win_start > TIME_W'(20) && $urandom_range(0, 3) == 0)
      t = 64'(win_start) - 64'($urandom_range(1, 20));
    else
      t = 64'(win_start) + 64'($urandom_range(0, 32'(weff)));
    return (t > 64'(TIME_MAX)) ? 64'(TIME_MAX) : t;
  endfunction

  // Mostly forward steps inside a bucket or to the next one, sometimes a jump
  // over empty buckets, now and then a step backwards.
  function automatic logic [63:0] next_stamp(input logic [63:0] t, input logic [63:0] weff);
    logic [63:0] n;
    logic [63:0] back;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) n = t + 64'($urandom_range(0, 32'(weff / 3)));
    else if (pick < 78) n = t + weff;
    else if (pick < 90) n = t + weff * 64'($urandom_range(3, 20));
    else if (pick < 95) n = t;
    else begin
      back = 64'($urandom_range(0, 32'(weff)));
      n = (back > t) ? 64'd0 : t - back;
    end
    return (n > 64'(TIME_MAX)) ? 64'(TIME_MAX) : n;
  endfunction

  task automatic random_window();
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    logic [BW_W-1:0]   w;
    logic [63:0]       weff;
    logic [63:0]       top;
    case ($urandom_range(0, 5))
      0:       s = '0;
      1:       s = TIME_MAX - TIME_W'($urandom_range(0, 1000000));
      default: s = rand48() >> $urandom_range(0, 47);
    endcase
    case ($urandom_range(0, 6))
      0:       w = '0;
      1:       w = 32'd1;
      2:       w = 32'd60000;
      3:       w = '1;
      4:       w = $urandom;
      default: w = $urandom_range(2, 5000);
    endcase
    weff = (w == '0) ? 64'd1 : 64'(w);
    top  = 64'(s) + weff * 64'($urandom_range(3, 200));
    if ($urandom_range(0, 3) == 0 || top > 64'(TIME_MAX)) e = TIME_MAX;
    else e = top[TIME_W-1:0];
    // Moving only the start while a bucket is open; the old window must still
    // leave room for a few buckets so streams keep landing in range.
    weff = (win_width == '0) ? 64'd1 : 64'(win_width);
    if (acc_live && $urandom_range(0, 2) == 0 && 64'(s) + 64'd3 * weff <= 64'(win_end))
      set_start(s);
    else
      set_window(s, e, w);
  endtask

  task automatic run_phase(input int budget);
    logic [63:0] t;
    logic [63:0] weff;
    item_t       it;
    int          taken;
    taken = 0;
    weff  = (win_width == '0) ? 64'd1 : 64'(win_width);
    t     = stream_start(weff);
    while (taken < budget) begin
      it = rand_rec(t[TIME_W-1:0], ($urandom_range(0, 24) == 0) || (t > 64'(win_end)));
      if ($urandom_range(0, 29) == 0) it.stamp = rand48();
      send_rec(it);
      if (it.stamp >= win_start && it.stamp <= win_end) taken++;
      if (it.end_of_stream) t = stream_start(weff);
      else t = next_stamp(t, weff);
    end
  endtask

  // Reset values of the registers: 60 s buckets from time zero.
  task automatic test_default_buckets();
    send_rec(rec_of(48'd0, PRICE_MAX, PRICE_MAX, '0, 24'h000100, '1, 1'b0));
    send_rec(rec_of(48'd59999, 24'h000200, 24'h000300, 24'h000080, 24'h000250, '0, 1'b0));
    send_rec(rec_of(48'd60000, 24'h001000, 24'h001100, 24'h000F00, 24'h001050, 32'd500, 1'b0));
    send_rec(rec_of(48'd60001, '0, '0, '0, '0, 32'd7, 1'b0));
    // Crosses a bucket and ends the stream: two bars from one word.
    send_rec(rec_of(48'd120500, 24'h002000, 24'h002200, 24'h001E00, 24'h002100, 32'd9, 1'b1));
    send_rec(rec_of(48'd130000, 24'h000500, 24'h000600, 24'h000400, 24'h000550, '0, 1'b1));
    send_rec(rec_of(TIME_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX, '1, 1'b1));
    settle();
  endtask

  task automatic test_query_window();
    set_window(48'd1000, 48'd5000, 32'd300);
    send_rec(rec_of(48'd999, 24'h000111, 24'h000222, 24'h000011, 24'h000122, 32'd3, 1'b0));
    send_rec(rec_of(48'd1000, 24'h000400, 24'h000500, 24'h000300, 24'h000450, 32'd10, 1'b0));
    send_rec(rec_of(48'd1299, 24'h000410, 24'h000600, 24'h000200, 24'h000420, 32'd20, 1'b0));
    send_rec(rec_of(48'd2500, 24'h000700, 24'h000800, 24'h000600, 24'h000750, 32'd5, 1'b0));
    send_rec(rec_of(48'd2300, 24'h000900, 24'h000A00, 24'h000500, 24'h000880, 32'd6, 1'b0));
    send_rec(rec_of(48'd5000, 24'h000100, 24'h000180, 24'h000080, 24'h000120, 32'd1, 1'b0));
    send_rec(rec_of(48'd5001, 24'h000333, 24'h000444, 24'h000222, 24'h000333, 32'd8, 1'b1));
    send_rec(rec_of(48'd6000, 24'h000333, 24'h000444, 24'h000222, 24'h000333, 32'd8, 1'b1));
    send_rec(rec_of(48'd3000, 24'h000010, 24'h000020, 24'h000008, 24'h000018, 32'd2, 1'b0));
    send_rec(rec_of(48'd3100, 24'h000011, 24'h000030, 24'h000004, 24'h000019, 32'd4, 1'b1));
    settle();
  endtask

  task automatic test_register_edges();
    set_window(TIME_MAX, TIME_MAX, '1);
    send_rec(rec_of(TIME_MAX, 24'h123456, 24'h654321, 24'h000001, 24'h0ABCDE, 32'd77, 1'b1));
    send_rec(rec_of(TIME_MAX - 1, 24'h123456, 24'h654321, 24'h000001, 24'h0ABCDE, 32'd7, 1'b1));
    settle();
    // Start beyond end: nothing gets through.
    set_window(48'd5000, 48'd4000, 32'd10);
    send_rec(rec_of(48'd4500, 24'h000100, 24'h000200, 24'h000050, 24'h000150, 32'd9, 1'b0));
    send_rec(rec_of(48'd5000, 24'h000100, 24'h000200, 24'h000050, 24'h000150, 32'd9, 1'b1));
    settle();
    // A width of zero acts as one millisecond.
    set_window('0, TIME_MAX, '0);
    send_rec(rec_of(48'd7, 24'h000100, 24'h000200, 24'h000050, 24'h000150, 32'd9, 1'b0));
    send_rec(rec_of(48'd7, 24'h000110, 24'h000210, 24'h000040, 24'h000160, 32'd1, 1'b0));
    send_rec(rec_of(48'd8, 24'h000120, 24'h000220, 24'h000060, 24'h000170, 32'd2, 1'b1));
    settle();
    // A new start with a bucket open leaves that bucket where it is.
    set_window('0, TIME_MAX, 32'd100);
    send_rec(rec_of(48'd250, 24'h000300, 24'h000400, 24'h000200, 24'h000350, 32'd40, 1'b0));
    settle();
    set_start(48'd100);
    send_rec(rec_of(48'd150, 24'h000310, 24'h000500, 24'h000100, 24'h000330, 32'd60, 1'b0));
    send_rec(rec_of(48'd420, 24'h000320, 24'h000420, 24'h000220, 24'h000340, 32'd5, 1'b0));
    send_rec(rec_of(48'd450, 24'h000330, 24'h000430, 24'h000230, 24'h000345, 32'd6, 1'b1));
    settle();
  endtask

  // Max prices and volume into one bucket: the weighted sum saturates after
  // about 128 words, the volume sum after 257.
  task automatic test_saturation();
    set_window('0, TIME_MAX, '1);
    for (int i = 0; i < 260; i++)
      send_rec(rec_of(TIME_W'(5 + i), PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX, '1, i == 259));
    settle();
  endtask

  // One-millisecond buckets make every word after the first close a bar, so a long sink hold
  // fills the output register and stalls the input.
  task automatic test_backpressure();
    set_window('0, TIME_MAX, 32'd1);
    sink_hold_req = HOLD_CYCLES;
    for (int i = 0; i < 40; i++)
      send_rec(rand_rec(TIME_W'(10 * (i + 1)), i == 39));
    settle();
  endtask

  task automatic test_random_streams();
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) idle_on = 1'b0;
      random_window();
      run_phase(PHASE_ITEMS);
      settle();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    rec_valid <= 1'b0;
    rec       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_START;
    cfg_data  <= '0;
    reset_predictor();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_buckets();
    test_query_window();
    test_register_edges();
    test_saturation();
    test_backpressure();
    test_random_streams();
    settle();
    if (failed || bars_due.size() != 0)
      $display("Test completed with failures");
    else
      $display("Test completed successfully");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
src/obr_pkg.sv
src/obr_div.sv
src/obr_dp.sv
src/obr_ctrl.sv
src/ohlcv_bucket_resampler.sv
tb/tb_ohlcv_bucket_resampler.sv
